>>> rtl/core/fvn_pkg.sv
`default_nettype none
package fvn_pkg;

    // Field widths of the channels.
    localparam int unsigned COORD_W = 24;
    localparam int unsigned NOISE_W = 16;
    localparam int unsigned SEED_W  = 32;
    localparam int unsigned INVS_W  = 24;
    localparam int unsigned OCT_W   = 4;
    localparam int unsigned PERS_W  = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    // Default octave limit.
    localparam int unsigned MAX_OCTAVES_DEF = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SEED  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVS  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OCT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERS  = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [SEED_W-1:0] SEED_RST = 32'd0;
    localparam logic [INVS_W-1:0] INVS_RST = 24'd838861;
    localparam logic [OCT_W-1:0]  OCT_RST  = 4'd4;
    localparam logic [PERS_W-1:0] PERS_RST = 16'd32768;

    // Hash and octave constants.
    localparam logic [31:0] HASH_MUL_X  = 32'h9e3779b9;
    localparam logic [31:0] HASH_MUL_Y  = 32'h85ebca6b;
    localparam logic [31:0] HASH_MUL_A  = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL_B  = 32'h846ca68b;
    localparam logic [31:0] OCT_SEED_STEP = 32'h68bc21eb;
    localparam logic [NOISE_W-1:0] HALF_Q16 = 16'h8000;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [17:0] THREE_Q16 = 18'd196608;

    // Octave frequency 2.03^k in Q8.16, saturated from octave 8 on.
    function automatic logic [23:0] freq_of(input logic [3:0] k);
        logic [23:0] f;
        case (k)
            4'd0:    f = 24'd65536;
            4'd1:    f = 24'd133038;
            4'd2:    f = 24'd270067;
            4'd3:    f = 24'd548237;
            4'd4:    f = 24'd1112920;
            4'd5:    f = 24'd2259228;
            4'd6:    f = 24'd4586233;
            4'd7:    f = 24'd9310054;
            default: f = 24'hFFFFFF;
        endcase
        return f;
    endfunction

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_OCT  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

endpackage
`default_nettype wire

>>> rtl/core/fvn_if.sv
`default_nettype none
// Point request channel.
interface fvn_pt_if;
    logic                          valid;
    logic                          ready;
    logic [fvn_pkg::COORD_W-1:0]   x_coord;
    logic [fvn_pkg::COORD_W-1:0]   y_coord;
    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// Noise result channel.
interface fvn_res_if;
    logic                          valid;
    logic                          ready;
    logic [fvn_pkg::NOISE_W-1:0]   noise_value;
    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// Configuration write channel.
interface fvn_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fvn_pkg::CFG_IDX_W-1:0]   index;
    logic [fvn_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fractal_value_noise.sv
`default_nettype none
// Channel   Dir  Payload                         Accept
// i_pt      in   x_coord, y_coord (s Q15.8)      valid & ready
// o_res     out  noise_value (u Q0.16)           valid & ready
// i_cfg     in   index, data                     valid & ready (ready always high)
//
// One point runs the octave steps once per octave, then the divide, then the
// handoff; its pace is set by the single shared 33x33 multiplier that every
// product of an octave passes through, and by the one-bit-per-cycle divider.
// With zero octaves the request skips the octave steps and the divide and goes to S_OUT.
// Reset (synchronous, active low) restores the register defaults and idles.
// A result waiting on a stalled output does not block the next request.
module fractal_value_noise #(
    parameter int unsigned MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fvn_pt_if.sink     i_pt,
    fvn_res_if.source  o_res,
    fvn_cfg_if.sink    i_cfg
);

    localparam int unsigned ASUM_W = 17 + $clog2(MAX_OCTAVES + 1);
    localparam int unsigned ACC_W  = 24 + ASUM_W;

    // Step codes of one octave.
    localparam logic [4:0] ST_CX_FREQ = 5'd0;
    localparam logic [4:0] ST_CX_LO   = 5'd1;
    localparam logic [4:0] ST_CX_HI   = 5'd2;
    localparam logic [4:0] ST_CY_FREQ = 5'd3;
    localparam logic [4:0] ST_CY_LO   = 5'd4;
    localparam logic [4:0] ST_CY_HI   = 5'd5;
    localparam logic [4:0] ST_SX_SQ   = 5'd6;
    localparam logic [4:0] ST_SX_POLY = 5'd7;
    localparam logic [4:0] ST_SY_SQ   = 5'd8;
    localparam logic [4:0] ST_SY_POLY = 5'd9;
    localparam logic [4:0] ST_HX      = 5'd10;
    localparam logic [4:0] ST_HY      = 5'd11;
    localparam logic [4:0] ST_HA0     = 5'd12;
    localparam logic [4:0] ST_HB0     = 5'd13;
    localparam logic [4:0] ST_HA1     = 5'd14;
    localparam logic [4:0] ST_HB1     = 5'd15;
    localparam logic [4:0] ST_HA2     = 5'd16;
    localparam logic [4:0] ST_HB2     = 5'd17;
    localparam logic [4:0] ST_HA3     = 5'd18;
    localparam logic [4:0] ST_HB3     = 5'd19;
    localparam logic [4:0] ST_TOP_A   = 5'd20;
    localparam logic [4:0] ST_TOP_B   = 5'd21;
    localparam logic [4:0] ST_BOT_A   = 5'd22;
    localparam logic [4:0] ST_BOT_B   = 5'd23;
    localparam logic [4:0] ST_MIX_A   = 5'd24;
    localparam logic [4:0] ST_MIX_B   = 5'd25;
    localparam logic [4:0] ST_ACC     = 5'd26;
    localparam logic [4:0] ST_AMP     = 5'd27;

    // Configuration registers.
    logic [fvn_pkg::SEED_W-1:0] r_cfg_seed;
    logic [fvn_pkg::INVS_W-1:0] r_inv;
    logic [fvn_pkg::OCT_W-1:0]  r_oct;
    logic [fvn_pkg::PERS_W-1:0] r_pers;

    // Control.
    fvn_pkg::t_state r_state;
    logic [4:0]      r_step;
    logic [3:0]      r_k;
    logic [3:0]      r_bit;
    logic            r_out_valid;

    // Datapath.
    logic [23:0]       r_sx, r_sy;
    logic [39:0]       r_t, r_cx, r_cy;
    logic [43:0]       r_lo;
    logic [15:0]       r_f2;
    logic [16:0]       r_ssx, r_ssy;
    logic [31:0]       r_hx0, r_hy0, r_h, r_seed;
    logic [23:0]       r_corner [4];
    logic [23:0]       r_top, r_bot, r_noise;
    logic [16:0]       r_amp;
    logic [ASUM_W-1:0] r_amp_sum;
    logic [ACC_W-1:0]  r_acc, r_rem, r_dsr;
    logic [15:0]       r_q, r_out_data;

    logic signed [32:0] m_a, m_b;
    logic signed [65:0] m_p;
    logic [23:0]        coord;
    logic [1:0]         hj;
    logic [31:0]        hx, hy, h0, h1, h2, h3;
    logic [63:0]        coord_sum;
    logic [41:0]        lerp_sum;
    logic [4:0]         oct_lim;
    logic               last_oct, rem_ge, pt_acc;
    logic [ACC_W-1:0]   rem_sub;

    assign i_cfg.ready = 1'b1;
    assign i_pt.ready  = (r_state == fvn_pkg::S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.noise_value = r_out_data;
    assign pt_acc = i_pt.valid & i_pt.ready;

    // Effective octave count and last-octave flag.
    assign oct_lim  = ({1'b0, r_oct} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : {1'b0, r_oct};
    assign last_oct = (({1'b0, r_k} + 5'd1) == oct_lim);

    // Hash operands for the corner of the current step.
    assign coord = (r_step < ST_CY_FREQ) ? r_sx : r_sy;
    assign hj    = 2'((r_step - ST_HA0) >> 1);
    assign hx    = hj[0] ? (r_hx0 + fvn_pkg::HASH_MUL_X) : r_hx0;
    assign hy    = hj[1] ? (r_hy0 + fvn_pkg::HASH_MUL_Y) : r_hy0;
    assign h0    = r_seed ^ hx ^ hy;
    assign h1    = h0 ^ (h0 >> 16);
    assign h2    = r_h ^ (r_h >> 15);
    assign h3    = m_p[31:0];

    // Shared multiplier operand selection.
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_step) inside
            ST_CX_FREQ, ST_CY_FREQ: begin
                m_a = {{9{coord[23]}}, coord};
                m_b = {9'd0, fvn_pkg::freq_of(r_k)};
            end
            ST_CX_LO, ST_CY_LO: begin
                m_a = {13'd0, r_t[19:0]};
                m_b = {9'd0, r_inv};
            end
            ST_CX_HI, ST_CY_HI: begin
                m_a = {{13{r_t[39]}}, r_t[39:20]};
                m_b = {9'd0, r_inv};
            end
            ST_SX_SQ: begin
                m_a = {17'd0, r_cx[15:0]};
                m_b = {17'd0, r_cx[15:0]};
            end
            ST_SX_POLY: begin
                m_a = {17'd0, r_f2};
                m_b = {15'd0, fvn_pkg::THREE_Q16 - {1'b0, r_cx[15:0], 1'b0}};
            end
            ST_SY_SQ: begin
                m_a = {17'd0, r_cy[15:0]};
                m_b = {17'd0, r_cy[15:0]};
            end
            ST_SY_POLY: begin
                m_a = {17'd0, r_f2};
                m_b = {15'd0, fvn_pkg::THREE_Q16 - {1'b0, r_cy[15:0], 1'b0}};
            end
            ST_HX: begin
                m_a = {1'b0, {{8{r_cx[39]}}, r_cx[39:16]}};
                m_b = {1'b0, fvn_pkg::HASH_MUL_X};
            end
            ST_HY: begin
                m_a = {1'b0, {{8{r_cy[39]}}, r_cy[39:16]}};
                m_b = {1'b0, fvn_pkg::HASH_MUL_Y};
            end
            ST_HA0, ST_HA1, ST_HA2, ST_HA3: begin
                m_a = {1'b0, h1};
                m_b = {1'b0, fvn_pkg::HASH_MUL_A};
            end
            ST_HB0, ST_HB1, ST_HB2, ST_HB3: begin
                m_a = {1'b0, h2};
                m_b = {1'b0, fvn_pkg::HASH_MUL_B};
            end
            ST_TOP_A: begin
                m_a = {9'd0, r_corner[0]};
                m_b = {16'd0, fvn_pkg::ONE_Q16 - r_ssx};
            end
            ST_TOP_B: begin
                m_a = {9'd0, r_corner[1]};
                m_b = {16'd0, r_ssx};
            end
            ST_BOT_A: begin
                m_a = {9'd0, r_corner[2]};
                m_b = {16'd0, fvn_pkg::ONE_Q16 - r_ssx};
            end
            ST_BOT_B: begin
                m_a = {9'd0, r_corner[3]};
                m_b = {16'd0, r_ssx};
            end
            ST_MIX_A: begin
                m_a = {9'd0, r_top};
                m_b = {16'd0, fvn_pkg::ONE_Q16 - r_ssy};
            end
            ST_MIX_B: begin
                m_a = {9'd0, r_bot};
                m_b = {16'd0, r_ssy};
            end
            ST_ACC: begin
                m_a = {9'd0, r_noise};
                m_b = {16'd0, r_amp};
            end
            ST_AMP: begin
                m_a = {16'd0, r_amp};
                m_b = {17'd0, r_pers};
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = m_a * m_b;

    // Scaled coordinate from high and low partial products, and lerp sums.
    assign coord_sum = {m_p[43:0], 20'd0} + {20'd0, r_lo};
    assign lerp_sum  = {1'b0, r_lo[40:0]} + {1'b0, m_p[40:0]};

    // Restoring divide step.
    assign rem_ge  = (r_rem >= r_dsr);
    assign rem_sub = rem_ge ? (r_rem - r_dsr) : r_rem;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_seed <= fvn_pkg::SEED_RST;
            r_inv      <= fvn_pkg::INVS_RST;
            r_oct      <= fvn_pkg::OCT_RST;
            r_pers     <= fvn_pkg::PERS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                fvn_pkg::REG_SEED: r_cfg_seed <= i_cfg.data;
                fvn_pkg::REG_INVS: r_inv      <= i_cfg.data[fvn_pkg::INVS_W-1:0];
                fvn_pkg::REG_OCT:  r_oct      <= i_cfg.data[fvn_pkg::OCT_W-1:0];
                fvn_pkg::REG_PERS: r_pers     <= i_cfg.data[fvn_pkg::PERS_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fvn_pkg::S_IDLE;
            r_step      <= ST_CX_FREQ;
            r_k         <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The result register fills from S_OUT and empties when taken.
            if (r_state == fvn_pkg::S_OUT && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                fvn_pkg::S_IDLE: begin
                    if (pt_acc) begin
                        r_step  <= ST_CX_FREQ;
                        r_k     <= '0;
                        r_state <= (oct_lim == 5'd0) ? fvn_pkg::S_OUT : fvn_pkg::S_OCT;
                    end
                end
                fvn_pkg::S_OCT: begin
                    if (r_step == ST_AMP) begin
                        r_step <= ST_CX_FREQ;
                        r_k    <= r_k + 4'd1;
                        if (last_oct) begin
                            r_bit   <= 4'd15;
                            r_state <= fvn_pkg::S_DIV;
                        end
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end
                fvn_pkg::S_DIV: begin
                    r_bit <= r_bit - 4'd1;
                    if (r_bit == 4'd0) begin
                        r_state <= fvn_pkg::S_OUT;
                    end
                end
                fvn_pkg::S_OUT: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_state <= fvn_pkg::S_IDLE;
                    end
                end
                default: r_state <= fvn_pkg::S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == fvn_pkg::S_IDLE && pt_acc) begin
            r_sx      <= i_pt.x_coord;
            r_sy      <= i_pt.y_coord;
            r_seed    <= r_cfg_seed;
            r_amp     <= fvn_pkg::ONE_Q16;
            r_amp_sum <= '0;
            r_acc     <= '0;
            r_q       <= fvn_pkg::HALF_Q16;
        end
        if (r_state == fvn_pkg::S_OUT && (!r_out_valid || o_res.ready)) begin
            r_out_data <= r_q;
        end
        if (r_state == fvn_pkg::S_DIV) begin
            r_rem <= rem_sub;
            r_dsr <= r_dsr >> 1;
            r_q   <= {r_q[14:0], rem_ge};
        end
        if (r_state == fvn_pkg::S_OCT) begin
            case (r_step) inside
                ST_CX_FREQ, ST_CY_FREQ: r_t <= m_p[47:8];
                ST_CX_LO, ST_CY_LO:     r_lo <= m_p[43:0];
                ST_CX_HI:               r_cx <= coord_sum[63:24];
                ST_CY_HI:               r_cy <= coord_sum[63:24];
                ST_SX_SQ, ST_SY_SQ:     r_f2 <= m_p[31:16];
                ST_SX_POLY:             r_ssx <= m_p[32:16];
                ST_SY_POLY:             r_ssy <= m_p[32:16];
                ST_HX:                  r_hx0 <= m_p[31:0];
                ST_HY:                  r_hy0 <= m_p[31:0];
                ST_HA0, ST_HA1, ST_HA2, ST_HA3: r_h <= m_p[31:0];
                ST_HB0, ST_HB1, ST_HB2, ST_HB3: r_corner[hj] <= h3[23:0] ^ {8'd0, h3[31:16]};
                ST_TOP_A, ST_BOT_A, ST_MIX_A:   r_lo <= {3'd0, m_p[40:0]};
                ST_TOP_B:               r_top <= lerp_sum[39:16];
                ST_BOT_B:               r_bot <= lerp_sum[39:16];
                ST_MIX_B:               r_noise <= lerp_sum[39:16];
                ST_ACC: begin
                    r_acc     <= r_acc + ACC_W'(m_p[40:0]);
                    r_amp_sum <= r_amp_sum + ASUM_W'(r_amp);
                end
                ST_AMP: begin
                    r_amp  <= m_p[32:16];
                    r_seed <= r_seed + fvn_pkg::OCT_SEED_STEP;
                    r_rem  <= r_acc;
                    r_dsr  <= ACC_W'({r_amp_sum, 23'd0});
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/fvn_checker.sv
`default_nettype none
module fvn_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_out_data,
    input wire logic        i_cfg_ready
);

    // A request closes the input until its result is on its way.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input stayed open after a request");

    // A held result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // Reset empties the output.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Configuration writes are never stalled.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port stalled");

endmodule

bind fractal_value_noise fvn_checker u_fvn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.noise_value),
    .i_cfg_ready (i_cfg.ready)
);
`default_nettype wire
